FILE: sv/nps_pkg.sv
`default_nettype none

package nps_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int LEN_BITS     = 6;
    localparam int PAT_BYTES    = 32;
    localparam int RES_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LEN   = 3'd4;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd4;

    typedef logic [7:0] t_byte;
    typedef logic [PAT_BYTES-1:0][7:0] t_pat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in;

    typedef struct packed {
        logic                is_match;
        logic [RES_BITS-1:0] match_offset;
        logic                region_done;
        logic [RES_BITS-1:0] match_total;
    } t_out;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

`default_nettype wire

FILE: sv/nps_window.sv
`default_nettype none

module nps_window
    import nps_pkg::*;
#(
    parameter int P = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_win_ctl            i_ctl,
    input  wire t_byte               i_byte,
    input  wire t_pat                i_pattern,
    input  wire logic [LEN_BITS-1:0] i_len,
    output logic                     o_all_equal
);

    localparam int SEL_BITS = $clog2(PAT_BYTES);

    t_byte               r_win [P];
    t_byte               n_win [P];
    logic [P-1:0]        eq;
    logic [SEL_BITS-1:0] k [P];

    // newest byte sits at index 0
    always_comb begin
        n_win[0] = i_byte;
        for (int j = 1; j < P; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // window slot j lines up with pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < P; j++) begin
            k[j]  = SEL_BITS'(i_len - LEN_BITS'(1) - LEN_BITS'(j));
            eq[j] = (LEN_BITS'(j) >= i_len) || (n_win[j] == i_pattern[k[j]]);
        end
    end

    assign o_all_equal = &eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int j = 0; j < P; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

FILE: sv/nonoverlapping_pattern_scan.sv
`default_nettype none

// Non-overlapping byte pattern scanner. One region byte enters per request,
// with region_end on its last byte; the pattern (1 to MAX_PATTERN bytes, set
// by the four pattern registers and pattern_length) is compared against the
// byte window in parallel, so a byte is taken every cycle while the input is
// not stalled; its result is registered. A result is produced when a match
// completes (start offset in match_offset) and on the region's last byte
// (match_total final, all scan state cleared). Matches do not overlap: after a
// hit the next len-1 candidate starts are skipped. A two-entry output buffer
// lets input keep flowing for one result while the output side is stalled.
// Configuration must be written only while no request is in flight; a
// pattern_length of 0 acts as 1 and values above MAX_PATTERN are clamped.
module nonoverlapping_pattern_scan
    import nps_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_in                     i_in_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    output t_out                         o_out_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [63:0]             i_cfg_data
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_PATTERN);

    logic [63:0]            r_pat [4];
    logic [LEN_BITS-1:0]    r_len;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [LEN_BITS-1:0]    r_sup;
    logic [RES_BITS-1:0]    r_cnt;
    t_out                   r_out;
    logic                   r_out_valid;
    t_out                   r_skid;
    logic                   r_skid_valid;

    logic [OFFSET_BITS-1:0] n_pos;
    logic [LEN_BITS-1:0]    n_sup;
    logic [RES_BITS-1:0]    n_cnt;
    t_out                   n_res;

    logic                   in_acc;
    logic                   out_take;
    logic                   produce;
    logic                   hit;
    logic                   all_equal;
    logic [LEN_BITS-1:0]    len_eff;
    logic [LEN_BITS-1:0]    len_m1;
    logic [OFFSET_BITS-1:0] offset;
    t_pat                   pattern;
    t_win_ctl               win_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (r_len > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = r_len;
        end
    end
    assign len_m1  = len_eff - LEN_BITS'(1);
    assign pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    assign win_ctl.shift = in_acc;
    assign win_ctl.clear = in_acc && i_in_data.region_end;

    nps_window #(
        .P (MAX_PATTERN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (win_ctl),
        .i_byte      (i_in_data.data_byte),
        .i_pattern   (pattern),
        .i_len       (len_eff),
        .o_all_equal (all_equal)
    );

    assign hit     = (r_sup == '0) && (r_pos >= OFFSET_BITS'(len_m1)) && all_equal;
    assign offset  = r_pos - OFFSET_BITS'(len_m1);
    assign produce = in_acc && (hit || i_in_data.region_end);

    always_comb begin
        n_pos = (r_pos != '1) ? r_pos + OFFSET_BITS'(1) : r_pos;
        n_cnt = (hit && r_cnt != '1) ? r_cnt + RES_BITS'(1) : r_cnt;
        if (r_sup != '0) begin
            n_sup = r_sup - LEN_BITS'(1);
        end else if (hit) begin
            n_sup = len_m1;
        end else begin
            n_sup = r_sup;
        end
        n_res.is_match     = hit;
        n_res.match_offset = hit ? RES_BITS'(offset) : '0;
        n_res.region_done  = i_in_data.region_end;
        n_res.match_total  = n_cnt;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                r_pat[r] <= '0;
            end
            r_len <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAT_0_7:   r_pat[0] <= i_cfg_data;
                CFG_PAT_8_15:  r_pat[1] <= i_cfg_data;
                CFG_PAT_16_23: r_pat[2] <= i_cfg_data;
                CFG_PAT_24_31: r_pat[3] <= i_cfg_data;
                CFG_PAT_LEN:   r_len    <= i_cfg_data[LEN_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sup <= '0;
            r_cnt <= '0;
        end else if (in_acc) begin
            if (i_in_data.region_end) begin
                r_pos <= '0;
                r_sup <= '0;
                r_cnt <= '0;
            end else begin
                r_pos <= n_pos;
                r_sup <= n_sup;
                r_cnt <= n_cnt;
            end
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (produce) begin
                r_out <= n_res;
            end
        end else if (produce) begin
            r_skid <= n_res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_sup_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sup <= LEN_BITS'(MAX_PATTERN - 1))
        else $error("suppression count beyond pattern length");

    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.region_end) |=> (r_pos == '0 && r_cnt == '0 && r_sup == '0))
        else $error("scan state not cleared after region end");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.region_end) |=> (r_cnt >= $past(r_cnt)))
        else $error("match count went down inside a region");

    a_hit_not_suppressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && hit) |=> (r_sup == $past(len_m1) || $past(i_in_data.region_end)))
        else $error("suppression not armed after match");

endmodule

`default_nettype wire
